// ===== rtl/core/rct_pkg.sv =====
package rct_pkg;

	localparam int NUM_ENTRIES = 16;
	localparam int KEY_W       = 32;
	localparam int ADDR_W      = 48;
	localparam int CNT_W       = 16;

	localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
	localparam logic signed [CNT_W-1:0] CNT_ONE = {{(CNT_W-1){1'b0}}, 1'b1};

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_INC    = 2'd1,
		CMD_DEC    = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	// classified command as it travels from front to back
	typedef struct packed {
		logic                    is_insert;
		logic                    is_inc;
		logic                    is_dec;
		logic                    is_remove;
		logic signed [KEY_W-1:0] key;
		logic [ADDR_W-1:0]       address;
	} op_t;

	typedef struct packed {
		status_t                 status;
		logic signed [CNT_W-1:0] ref_count;
	} res_t;

endpackage

// ===== rtl/core/rct_front.sv =====
module rct_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic [1:0]                        cmd,
	input  logic signed [rct_pkg::KEY_W-1:0]  entry_id,
	input  logic [rct_pkg::ADDR_W-1:0]        entry_address,
	output logic                              full,
	output logic                              op_valid,
	output rct_pkg::op_t                      op,
	input  logic                              op_pop
);
	import rct_pkg::*;

	op_t        decoded;
	op_t        slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	// decode the command into one flag per operation
	always_comb begin
		decoded           = '0;
		decoded.key       = entry_id;
		decoded.address   = entry_address;
		unique case (cmd_t'(cmd))
			CMD_INSERT: decoded.is_insert = 1'b1;
			CMD_INC:    decoded.is_inc    = 1'b1;
			CMD_DEC:    decoded.is_dec    = 1'b1;
			CMD_REMOVE: decoded.is_remove = 1'b1;
		endcase
	end

	assign full     = cnt_q[1];
	assign op_valid = (cnt_q != 2'd0);
	assign op       = slot_q[rd_ptr_q];
	assign do_push  = push & ~full;
	assign do_pop   = op_pop & op_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= decoded;
	end

endmodule

// ===== rtl/core/rct_back.sv =====
module rct_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	input  rct_pkg::op_t  op,
	output logic          op_pop,
	output logic          res_push,
	output rct_pkg::res_t res,
	input  logic          res_full
);
	import rct_pkg::*;

	typedef enum logic [1:0] {
		BK_FETCH = 2'b01,
		BK_EXEC  = 2'b10
	} bk_state_t;

	bk_state_t               state_q;
	logic [NUM_ENTRIES-1:0]  valid_q;
	logic signed [KEY_W-1:0] key_q   [NUM_ENTRIES];
	logic [ADDR_W-1:0]       addr_q  [NUM_ENTRIES];
	logic signed [CNT_W-1:0] count_q [NUM_ENTRIES];

	op_t                     op_s1;
	logic [NUM_ENTRIES-1:0]  first_s1;
	logic [NUM_ENTRIES-1:0]  after_s1;

	logic [NUM_ENTRIES-1:0]  match;
	logic [NUM_ENTRIES-1:0]  first;
	logic [NUM_ENTRIES-1:0]  after;
	logic [CNT_W-1:0]        hit_bits;
	logic signed [CNT_W-1:0] hit_count;
	logic signed [CNT_W-1:0] new_count;
	logic                    found;
	logic                    tbl_full;
	logic                    exec_fire;
	logic                    do_insert;
	logic                    do_adjust;
	logic                    do_remove;

	// newest-first search: first hit and everything at or after it
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == op.key);
			first[i] = match[i] & ~seen;
			seen     = seen | match[i];
			after[i] = seen;
		end
	end

	assign op_pop    = (state_q == BK_FETCH) && op_valid;
	assign exec_fire = (state_q == BK_EXEC) && !res_full;
	assign res_push  = exec_fire;

	always_comb begin
		hit_bits = '0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			hit_bits = hit_bits | (count_q[i] & {CNT_W{first_s1[i]}});
		end
	end

	assign hit_count = hit_bits;
	assign found     = after_s1[NUM_ENTRIES-1];
	assign tbl_full  = valid_q[NUM_ENTRIES-1];

	// saturating step
	always_comb begin
		new_count = hit_count;
		if (op_s1.is_inc && hit_count != CNT_MAX) new_count = hit_count + CNT_ONE;
		if (op_s1.is_dec && hit_count != CNT_MIN) new_count = hit_count - CNT_ONE;
	end

	always_comb begin
		res.ref_count = '0;
		if (op_s1.is_insert) begin
			res.status = tbl_full ? STAT_FULL : STAT_DONE;
		end else if (!found) begin
			res.status = STAT_NOT_FOUND;
		end else begin
			res.status = STAT_DONE;
			if (op_s1.is_dec) res.ref_count = new_count;
		end
	end

	assign do_insert = exec_fire && op_s1.is_insert && !tbl_full;
	assign do_adjust = exec_fire && (op_s1.is_inc || op_s1.is_dec) && found;
	assign do_remove = exec_fire && op_s1.is_remove && found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_FETCH;
			valid_q <= '0;
		end else begin
			unique case (state_q)
				BK_FETCH: if (op_valid) state_q <= BK_EXEC;
				BK_EXEC:  if (!res_full) state_q <= BK_FETCH;
				default:  state_q <= BK_FETCH;
			endcase
			if (do_insert) begin
				valid_q[0] <= 1'b1;
				for (int i = 1; i < NUM_ENTRIES; i++) valid_q[i] <= valid_q[i-1];
			end else if (do_remove) begin
				for (int i = 0; i < NUM_ENTRIES - 1; i++) begin
					if (after_s1[i]) valid_q[i] <= valid_q[i+1];
				end
				valid_q[NUM_ENTRIES-1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_s1    <= op;
			first_s1 <= first;
			after_s1 <= after;
		end
		if (do_insert) begin
			key_q[0]   <= op_s1.key;
			addr_q[0]  <= op_s1.address;
			count_q[0] <= CNT_ONE;
			for (int i = 1; i < NUM_ENTRIES; i++) begin
				key_q[i]   <= key_q[i-1];
				addr_q[i]  <= addr_q[i-1];
				count_q[i] <= count_q[i-1];
			end
		end else if (do_adjust) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (first_s1[i]) count_q[i] <= new_count;
			end
		end else if (do_remove) begin
			// close the gap: the hit slot and all older ones pull from behind
			for (int i = 0; i < NUM_ENTRIES - 1; i++) begin
				if (after_s1[i]) begin
					key_q[i]   <= key_q[i+1];
					addr_q[i]  <= addr_q[i+1];
					count_q[i] <= count_q[i+1];
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_first_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EXEC) |-> $onehot0(first_s1))
		else $error("more than one first hit");

	a_exec_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EXEC && res_full) |=> (state_q == BK_EXEC))
		else $error("execute left while result queue full");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(((valid_q >> 1) & ~valid_q) == '0))
		else $error("valid slots not a prefix");

	a_pop_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |=> (state_q == BK_EXEC))
		else $error("popped command not executed");
`endif

endmodule

// ===== rtl/core/rct_resq.sv =====
module rct_resq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_push,
	input  rct_pkg::res_t in_res,
	output logic          full,
	output logic          empty,
	input  logic          pop,
	output rct_pkg::res_t head
);
	import rct_pkg::*;

	res_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = cnt_q[1];
	assign empty   = (cnt_q == 2'd0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = in_push & ~full;
	assign do_pop  = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= in_res;
	end

endmodule

// ===== rtl/core/reference_count_table_unit.sv =====
// Reference count table: a compacted stack of NUM_ENTRIES tracked pointers
// (identifier, address, signed 16-bit count), newest in slot 0, searched
// newest first. Commands enter through a queue-style port (push/full) and
// each produces exactly one result beat, delivered in order through a second
// queue-style port (empty/pop). A command waits at the head of the two-entry
// command queue while the table is searched; when the back end pops it, the
// command and its first hit are registered. In the execute state the update
// is applied and the result is posted once the result queue has room. The
// back end takes no new command until the last one has posted its result.
// Status is done, not found, or table full on insert; ref_count carries the
// new count after a decrement and is zero otherwise. Counts saturate at
// their signed bounds.
module reference_count_table_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// command side
	input  logic                              push,
	output logic                              full,
	input  logic [1:0]                        cmd,
	input  logic signed [rct_pkg::KEY_W-1:0]  entry_id,
	input  logic [rct_pkg::ADDR_W-1:0]        entry_address,
	// result side
	output logic                              empty,
	input  logic                              pop,
	output logic [1:0]                        status,
	output logic signed [rct_pkg::CNT_W-1:0]  ref_count
);
	import rct_pkg::*;

	logic op_valid;
	op_t  op;
	logic op_pop;
	logic res_push;
	res_t res;
	logic res_full;
	res_t head;

	// front end: decode and buffer commands
	rct_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.cmd           (cmd),
		.entry_id      (entry_id),
		.entry_address (entry_address),
		.full          (full),
		.op_valid      (op_valid),
		.op            (op),
		.op_pop        (op_pop)
	);

	// back end: table search and update
	rct_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_pop   (op_pop),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full)
	);

	// result buffer, decouples the table from the consumer
	rct_resq u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_push (res_push),
		.in_res  (res),
		.full    (res_full),
		.empty   (empty),
		.pop     (pop),
		.head    (head)
	);

	assign status    = head.status;
	assign ref_count = head.ref_count;

endmodule
